FILE: design/ttc_pkg.sv
`timescale 1ns / 1ps

package ttc_pkg;

  // default configuration
  localparam int PosBitsDef    = 16;
  localparam int QueueDepthDef = 4;
  localparam int FieldBits     = 16;

  typedef enum logic [2:0] {
    KindEnd    = 3'd0,
    KindPunct  = 3'd1,
    KindNumber = 3'd2,
    KindWord   = 3'd3,
    KindUpper  = 3'd4
  } token_kind_e;

  // input word: one text byte or the end marker
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_word_t;

  // output word: one token
  typedef struct packed {
    token_kind_e          token_kind;
    logic [FieldBits-1:0] token_start;
    logic [FieldBits-1:0] token_length;
    logic                 last_of_run;
  } out_word_t;

  // token without the run marker, as held in the queue
  typedef struct packed {
    token_kind_e          kind;
    logic [FieldBits-1:0] start;
    logic [FieldBits-1:0] length;
  } token_t;

  // one queue entry: all tokens caused by one input word
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } tok_rec_t;

endpackage

FILE: design/ttc_front.sv
`timescale 1ns / 1ps

module ttc_front #(
  parameter int PosBits = ttc_pkg::PosBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ttc_pkg::in_word_t in_word_i,
  output logic              rec_push_o,
  output ttc_pkg::tok_rec_t rec_o,
  input  logic              rec_full_i
);
  import ttc_pkg::*;

  localparam int ExtW = (PosBits > FieldBits) ? PosBits : FieldBits;

  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChQuest  = 8'h3F;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChDQuote = 8'h22;
  localparam logic [7:0] ChSQuote = 8'h27;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef enum logic [1:0] {
    ModeNone   = 2'd0,
    ModeNumber = 2'd1,
    ModeWord   = 2'd2
  } run_mode_e;

  function automatic logic [FieldBits-1:0] to_field(logic [PosBits-1:0] v);
    logic [ExtW-1:0] w;
    w = ExtW'(v);
    return w[FieldBits-1:0];
  endfunction

  run_mode_e          mode_q, mode_d;
  logic [PosBits-1:0] start_q, start_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic               upper_q, upper_d;

  logic [7:0] c;
  logic is_space, is_punct, is_digit, is_upper, is_lower, is_word;
  logic run_open, accept;
  token_t run_tok, end_tok, punct_tok;
  logic [1:0] n_res;

  assign c        = in_word_i.char_byte;
  assign is_space = (c == ChSpace) || (c >= ChTab && c <= ChCr);
  assign is_punct = (c == ChDot) || (c == ChComma) || (c == ChSemi) || (c == ChColon) ||
                    (c == ChBang) || (c == ChQuest) || (c == ChLParen) ||
                    (c == ChRParen) || (c == ChDQuote) || (c == ChSQuote);
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_upper = (c >= 8'h41) && (c <= 8'h5A);
  assign is_lower = (c >= 8'h61) && (c <= 8'h7A);
  assign is_word  = is_upper || is_lower || (c == ChUnder) || (c == ChDash);

  assign run_open = (mode_q == ModeNumber) || (mode_q == ModeWord);
  assign full     = rec_full_i;
  assign accept   = push && !rec_full_i;

  always_comb begin
    run_tok.kind   = (mode_q == ModeNumber) ? KindNumber :
                     (upper_q ? KindUpper : KindWord);
    run_tok.start  = to_field(start_q);
    run_tok.length = to_field(pos_q - start_q);
    end_tok.kind   = KindEnd;
    end_tok.start  = to_field(pos_q);
    end_tok.length = '0;
    punct_tok.kind   = KindPunct;
    punct_tok.start  = to_field(pos_q);
    punct_tok.length = FieldBits'(1);
  end

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    upper_d = upper_q;
    pos_d   = (pos_q == '1) ? pos_q : pos_q + 1'b1;
    n_res   = 2'd0;
    rec_o.two  = 1'b0;
    rec_o.tok0 = run_tok;
    rec_o.tok1 = end_tok;
    if (in_word_i.end_of_text) begin
      if (run_open) begin
        rec_o.two = 1'b1;
        n_res     = 2'd2;
      end else begin
        rec_o.tok0 = end_tok;
        n_res      = 2'd1;
      end
      mode_d  = ModeNone;
      start_d = '0;
      upper_d = 1'b0;
      pos_d   = '0;
    end else if (mode_q == ModeNumber && (is_digit || c == ChDot)) begin
      // number keeps running
    end else if (mode_q == ModeWord && is_word) begin
      if (is_lower) begin
        upper_d = 1'b0;
      end
    end else begin
      // close the open run first
      if (run_open) begin
        n_res = 2'd1;
      end
      mode_d  = ModeNone;
      upper_d = 1'b0;
      if (is_space) begin
        // skipped
      end else if (is_punct) begin
        if (run_open) begin
          rec_o.two  = 1'b1;
          rec_o.tok1 = punct_tok;
          n_res      = 2'd2;
        end else begin
          rec_o.tok0 = punct_tok;
          n_res      = 2'd1;
        end
      end else if (is_digit) begin
        mode_d  = ModeNumber;
        start_d = pos_q;
      end else if (is_word) begin
        mode_d  = ModeWord;
        start_d = pos_q;
        upper_d = is_upper;
      end
    end
  end

  assign rec_push_o = accept && (n_res != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNone;
      start_q <= '0;
      pos_q   <= '0;
      upper_q <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      upper_q <= upper_d;
    end
  end

endmodule

FILE: design/ttc_queue.sv
`timescale 1ns / 1ps

module ttc_queue #(
  parameter int Depth = ttc_pkg::QueueDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ttc_pkg::tok_rec_t rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output ttc_pkg::tok_rec_t rec_o,
  output logic              empty_o
);
  import ttc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tok_rec_t         mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

FILE: design/ttc_back.sv
`timescale 1ns / 1ps

module ttc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ttc_pkg::tok_rec_t  rec_i,
  input  logic               rec_empty_i,
  output logic               rec_pop_o,
  output logic               empty,
  input  logic               pop,
  output ttc_pkg::out_word_t out_word_o
);
  import ttc_pkg::*;

  out_word_t out_q, out_d;
  logic      valid_q, valid_d;
  token_t    second_q, second_d;
  logic      pend_q, pend_d;
  logic      slot_free;

  assign slot_free  = !valid_q || pop;
  assign rec_pop_o  = slot_free && !pend_q && !rec_empty_i;
  assign empty      = !valid_q;
  assign out_word_o = out_q;

  always_comb begin
    out_d    = out_q;
    valid_d  = valid_q && !pop;
    second_d = second_q;
    pend_d   = pend_q;
    if (slot_free) begin
      if (pend_q) begin
        // second token of a pair
        out_d.token_kind   = second_q.kind;
        out_d.token_start  = second_q.start;
        out_d.token_length = second_q.length;
        out_d.last_of_run  = 1'b1;
        valid_d            = 1'b1;
        pend_d             = 1'b0;
      end else if (!rec_empty_i) begin
        out_d.token_kind   = rec_i.tok0.kind;
        out_d.token_start  = rec_i.tok0.start;
        out_d.token_length = rec_i.tok0.length;
        out_d.last_of_run  = !rec_i.two;
        valid_d            = 1'b1;
        second_d           = rec_i.tok1;
        pend_d             = rec_i.two;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    second_q <= second_d;
  end

endmodule

FILE: design/text_token_classifier_core.sv
`timescale 1ns / 1ps

// channel   direction  handshake           word
// input     in         push / full         in_word_i  (char_byte, end_of_text)
// result    out        pop / empty         out_word_o (token_kind, token_start,
//                                                      token_length, last_of_run)
//
// the front takes one input word per cycle whenever the token queue has room
// a word causes zero, one or two tokens; tokens leave one per cycle while pop is
// high, so a closed run followed by punctuation or the end token leaves as two words
// the queue (QueueDepth entries) lets the front run ahead while pop is low
// reset clears run state, text position, queue pointers and the output valid flag
module text_token_classifier_core #(
  parameter int PosBits    = ttc_pkg::PosBitsDef,
  parameter int QueueDepth = ttc_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input side
  input  logic               push,
  output logic               full,
  input  ttc_pkg::in_word_t  in_word_i,
  // result side
  output logic               empty,
  input  logic               pop,
  output ttc_pkg::out_word_t out_word_o
);
  import ttc_pkg::*;

  // front to queue
  logic     f_push;
  tok_rec_t f_rec;
  logic     q_full;

  // queue to back
  tok_rec_t q_rec;
  logic     q_empty;
  logic     b_pop;

  // front: classify bytes, track the open run and position
  ttc_front #(
    .PosBits(PosBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .rec_push_o (f_push),
    .rec_o      (f_rec),
    .rec_full_i (q_full)
  );

  // short queue of token records between the two halves
  ttc_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .rec_i   (f_rec),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .rec_o   (q_rec),
    .empty_o (q_empty)
  );

  // back: split records into single tokens behind an output register
  ttc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (q_rec),
    .rec_empty_i (q_empty),
    .rec_pop_o   (b_pop),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

endmodule
